FILE: rtl/iisck_pkg.sv
// ----------------------------------------------------------------------------
// iisck_pkg: shared constants, types and microcode for the index sorter
// Sizes of the record store, widths of the key fields, the control word and
// status bundle between sequencer and datapath, and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package iisck_pkg;

  // store sizes
  localparam int MAX_RECORDS = 64;
  localparam int NAME_WORDS  = 7;

  // fixed field widths
  localparam int GRADE_W  = 8;
  localparam int SPEC_W   = 3;
  localparam int WORD_W   = 64;
  localparam int IN_WORDS = 7;
  localparam int RECNUM_W = 6;

  // derived widths
  localparam int REC_W    = $clog2(MAX_RECORDS);
  localparam int CNT_W    = $clog2(MAX_RECORDS + 1);
  localparam int WI_W     = $clog2(NAME_WORDS + 1);
  localparam int NW_IDX_W = (NAME_WORDS > 1) ? $clog2(NAME_WORDS) : 1;
  localparam int NA_DEPTH = MAX_RECORDS * NAME_WORDS;
  localparam int NA_W     = (NA_DEPTH > 1) ? $clog2(NA_DEPTH) : 1;
  localparam int KEY_W    = GRADE_W + SPEC_W;

  // sequencer widths
  localparam int PC_W   = 5;
  localparam int COND_W = 4;

  // microcode step addresses
  localparam logic [PC_W-1:0] S_IDLE    = PC_W'(0);
  localparam logic [PC_W-1:0] S_FULL    = PC_W'(1);
  localparam logic [PC_W-1:0] S_WNAME   = PC_W'(2);
  localparam logic [PC_W-1:0] S_TEST    = PC_W'(3);
  localparam logic [PC_W-1:0] S_RD      = PC_W'(4);
  localparam logic [PC_W-1:0] S_KEYRD   = PC_W'(5);
  localparam logic [PC_W-1:0] S_KEYCMP  = PC_W'(6);
  localparam logic [PC_W-1:0] S_NAMECMP = PC_W'(7);
  localparam logic [PC_W-1:0] S_NEXTW   = PC_W'(8);
  localparam logic [PC_W-1:0] S_NREAD   = PC_W'(9);
  localparam logic [PC_W-1:0] S_DECIDE  = PC_W'(10);
  localparam logic [PC_W-1:0] S_SHIFT   = PC_W'(11);
  localparam logic [PC_W-1:0] S_PLACE   = PC_W'(12);
  localparam logic [PC_W-1:0] S_LAST    = PC_W'(13);
  localparam logic [PC_W-1:0] S_ORD     = PC_W'(14);
  localparam logic [PC_W-1:0] S_EMIT    = PC_W'(15);
  localparam logic [PC_W-1:0] S_NEXTK   = PC_W'(16);
  localparam logic [PC_W-1:0] S_CLEAR   = PC_W'(17);

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER     = COND_W'(0);
  localparam logic [COND_W-1:0] C_ALWAYS    = COND_W'(1);
  localparam logic [COND_W-1:0] C_NO_IN     = COND_W'(2);
  localparam logic [COND_W-1:0] C_FULL      = COND_W'(3);
  localparam logic [COND_W-1:0] C_W_MORE    = COND_W'(4);
  localparam logic [COND_W-1:0] C_J_ZERO    = COND_W'(5);
  localparam logic [COND_W-1:0] C_KEY_NE    = COND_W'(6);
  localparam logic [COND_W-1:0] C_WORD_NE   = COND_W'(7);
  localparam logic [COND_W-1:0] C_W_LAST    = COND_W'(8);
  localparam logic [COND_W-1:0] C_NOT_AFTER = COND_W'(9);
  localparam logic [COND_W-1:0] C_NOT_LAST  = COND_W'(10);
  localparam logic [COND_W-1:0] C_OUT_BUSY  = COND_W'(11);
  localparam logic [COND_W-1:0] C_K_MORE    = COND_W'(12);

  // one control word
  typedef struct packed {
    logic              in_rdy;    // input request may be taken
    logic              ld_in;     // capture the new record
    logic              st_wr;     // write key and one name word at slot n
    logic              ord_rd_j;  // read order table at j-1
    logic              ld_rec;    // latch record number, restart word index
    logic              key_rd;    // read stored grade and specialty
    logic              name_rd;   // read stored name word
    logic              set_key;   // decide from grade and specialty
    logic              set_word;  // decide from current name word
    logic              wi_inc;    // advance word index
    logic              shift;     // order[j] <= rec, j--
    logic              place;     // order[j] <= n, n++
    logic              k_clr;     // start output walk
    logic              ord_rd_k;  // read order table at k
    logic              emit;      // load result register, k++
    logic              n_clr;     // empty the set
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } iisck_ctrl_t;

  // datapath status for jump conditions
  typedef struct packed {
    logic in_fire;
    logic full;
    logic w_last;
    logic j_zero;
    logic key_ne;
    logic word_ne;
    logic after;
    logic last;
    logic out_busy;
    logic k_more;
  } iisck_stat_t;

  // microcode table
  function automatic iisck_ctrl_t ucode(input logic [PC_W-1:0] pc);
    iisck_ctrl_t c;
    c = '0;
    unique case (pc)
      S_IDLE: begin
        c.in_rdy = 1'b1;
        c.ld_in  = 1'b1;
        c.cond   = C_NO_IN;
        c.target = S_IDLE;
      end
      S_FULL: begin
        c.cond   = C_FULL;
        c.target = S_LAST;
      end
      S_WNAME: begin
        c.st_wr  = 1'b1;
        c.wi_inc = 1'b1;
        c.cond   = C_W_MORE;
        c.target = S_WNAME;
      end
      S_TEST: begin
        c.ord_rd_j = 1'b1;
        c.cond     = C_J_ZERO;
        c.target   = S_PLACE;
      end
      S_RD: begin
        c.ld_rec = 1'b1;
      end
      S_KEYRD: begin
        c.key_rd  = 1'b1;
        c.name_rd = 1'b1;
      end
      S_KEYCMP: begin
        c.set_key = 1'b1;
        c.cond    = C_KEY_NE;
        c.target  = S_DECIDE;
      end
      S_NAMECMP: begin
        c.set_word = 1'b1;
        c.cond     = C_WORD_NE;
        c.target   = S_DECIDE;
      end
      S_NEXTW: begin
        c.wi_inc = 1'b1;
        c.cond   = C_W_LAST;
        c.target = S_DECIDE;
      end
      S_NREAD: begin
        c.name_rd = 1'b1;
        c.cond    = C_ALWAYS;
        c.target  = S_NAMECMP;
      end
      S_DECIDE: begin
        c.cond   = C_NOT_AFTER;
        c.target = S_PLACE;
      end
      S_SHIFT: begin
        c.shift  = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = S_TEST;
      end
      S_PLACE: begin
        c.place = 1'b1;
      end
      S_LAST: begin
        c.k_clr  = 1'b1;
        c.cond   = C_NOT_LAST;
        c.target = S_IDLE;
      end
      S_ORD: begin
        c.ord_rd_k = 1'b1;
      end
      S_EMIT: begin
        c.emit   = 1'b1;
        c.cond   = C_OUT_BUSY;
        c.target = S_EMIT;
      end
      S_NEXTK: begin
        c.cond   = C_K_MORE;
        c.target = S_ORD;
      end
      S_CLEAR: begin
        c.n_clr  = 1'b1;
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/iisck_if.sv
// ----------------------------------------------------------------------------
// iisck_if: request channels of the index sorter
// Input channel carries one record per request, output channel one sorted
// record number per request; both use valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface iisck_in_if;
  import iisck_pkg::*;
  logic                valid;
  logic                ready;
  logic [GRADE_W-1:0]  grade;
  logic [SPEC_W-1:0]   specialty;
  logic [WORD_W-1:0]   surname_w0;
  logic [WORD_W-1:0]   surname_w1;
  logic [WORD_W-1:0]   surname_w2;
  logic [WORD_W-1:0]   surname_w3;
  logic [WORD_W-1:0]   surname_w4;
  logic [WORD_W-1:0]   surname_w5;
  logic [WORD_W-1:0]   surname_w6;
  logic                last_record;

  modport source (
    output valid, grade, specialty, surname_w0, surname_w1, surname_w2,
           surname_w3, surname_w4, surname_w5, surname_w6, last_record,
    input  ready
  );
  modport sink (
    input  valid, grade, specialty, surname_w0, surname_w1, surname_w2,
           surname_w3, surname_w4, surname_w5, surname_w6, last_record,
    output ready
  );
endinterface

interface iisck_out_if;
  import iisck_pkg::*;
  logic                valid;
  logic                ready;
  logic [RECNUM_W-1:0] record_number;
  logic                last_of_run;

  modport source (output valid, record_number, last_of_run, input ready);
  modport sink   (input valid, record_number, last_of_run, output ready);
endinterface

`default_nettype wire

FILE: rtl/index_insertion_sort_composite_key.sv
// ----------------------------------------------------------------------------
// index_insertion_sort_composite_key: stable index insertion sorter
// Loads records, keeps their keys in RAM and inserts each record number into
// an order table (grade descending, specialty ascending, surname ascending).
// A request marked last drains the sorted record numbers and empties the set.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   in_chan   in    valid / ready    grade, specialty, surname_w0..6, last_record
//   out_chan  out   valid / ready    record_number, last_of_run
//
// Loading a record writes its key and its surname words, then walks the order
// table from its end: each stored entry is read and compared on grade and
// specialty and, on equal keys, one 64-bit surname word at a time out of the
// key RAMs, and is shifted up until an entry does not sort after the new one.
// A last request then reads and emits each result in turn and empties the
// set.
// Reset is synchronous; the set starts empty. A stalled output holds the
// sequencer in its emit step; new records are taken only in the idle step.
// ----------------------------------------------------------------------------
`default_nettype none

module index_insertion_sort_composite_key (
  input  wire logic clk,
  input  wire logic rst_n,
  iisck_in_if.sink    in_chan,
  iisck_out_if.source out_chan
);
  import iisck_pkg::*;

  iisck_ctrl_t ctrl;
  iisck_stat_t stat;

  // control registers
  logic [CNT_W-1:0]    n_r,   n_nxt;
  logic [CNT_W-1:0]    j_r,   j_nxt;
  logic [CNT_W-1:0]    k_r,   k_nxt;
  logic [WI_W-1:0]     wi_r,  wi_nxt;
  logic                after_r, after_nxt;
  logic                last_r,  last_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload registers
  logic [GRADE_W-1:0]  ng_r;
  logic [SPEC_W-1:0]   ns_r;
  logic [WORD_W-1:0]   name_r [NAME_WORDS];
  logic [REC_W-1:0]    rec_r;
  logic [RECNUM_W-1:0] out_rec_r;
  logic                out_last_r;

  logic                in_fire;
  logic                out_free;
  logic                emit_go;
  logic [WORD_W-1:0]   in_words [IN_WORDS];
  logic [CNT_W-1:0]    jm1;
  logic [KEY_W-1:0]    key_q;
  logic [WORD_W-1:0]   name_q;
  logic [REC_W-1:0]    ord_q;
  logic [GRADE_W-1:0]  sg;
  logic [SPEC_W-1:0]   ss;
  logic [WORD_W-1:0]   cur_word;
  logic                key_after;
  logic [NA_W-1:0]     name_waddr;
  logic [NA_W-1:0]     name_raddr;

  // handshakes
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign in_chan.ready = ctrl.in_rdy;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign emit_go       = ctrl.emit && out_free;

  assign in_words[0] = in_chan.surname_w0;
  assign in_words[1] = in_chan.surname_w1;
  assign in_words[2] = in_chan.surname_w2;
  assign in_words[3] = in_chan.surname_w3;
  assign in_words[4] = in_chan.surname_w4;
  assign in_words[5] = in_chan.surname_w5;
  assign in_words[6] = in_chan.surname_w6;

  // sequencer
  iisck_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // key compare against the stored entry
  assign sg        = key_q[KEY_W-1:SPEC_W];
  assign ss        = key_q[SPEC_W-1:0];
  assign key_after = (sg < ng_r) || ((sg == ng_r) && (ss > ns_r));
  assign cur_word  = name_r[wi_r[NW_IDX_W-1:0]];
  assign jm1       = j_r - CNT_W'(1);

  // status to sequencer
  always_comb begin
    stat          = '0;
    stat.in_fire  = in_fire;
    stat.full     = (n_r == CNT_W'(MAX_RECORDS));
    stat.w_last   = (wi_r == WI_W'(NAME_WORDS - 1));
    stat.j_zero   = (j_r == '0);
    stat.key_ne   = (sg != ng_r) || (ss != ns_r);
    stat.word_ne  = (name_q != cur_word);
    stat.after    = after_r;
    stat.last     = last_r;
    stat.out_busy = out_valid_r && !out_chan.ready;
    stat.k_more   = (k_r != n_r);
  end

  // key store: grade and specialty per record
  iisck_ram #(.WIDTH(KEY_W), .DEPTH(MAX_RECORDS)) u_key_ram (
    .clk   (clk),
    .we    (ctrl.st_wr),
    .waddr (n_r[REC_W-1:0]),
    .wdata ({ng_r, ns_r}),
    .re    (ctrl.key_rd),
    .raddr (rec_r),
    .rdata (key_q)
  );

  // name store: NAME_WORDS words per record
  assign name_waddr = NA_W'(n_r[REC_W-1:0] * NAME_WORDS) + NA_W'(wi_r);
  assign name_raddr = NA_W'(rec_r * NAME_WORDS) + NA_W'(wi_r);

  iisck_ram #(.WIDTH(WORD_W), .DEPTH(NA_DEPTH)) u_name_ram (
    .clk   (clk),
    .we    (ctrl.st_wr),
    .waddr (name_waddr),
    .wdata (cur_word),
    .re    (ctrl.name_rd),
    .raddr (name_raddr),
    .rdata (name_q)
  );

  // order table of record numbers
  iisck_ram #(.WIDTH(REC_W), .DEPTH(MAX_RECORDS)) u_ord_ram (
    .clk   (clk),
    .we    (ctrl.shift || ctrl.place),
    .waddr (j_r[REC_W-1:0]),
    .wdata (ctrl.shift ? rec_r : n_r[REC_W-1:0]),
    .re    (ctrl.ord_rd_j || ctrl.ord_rd_k),
    .raddr (ctrl.ord_rd_k ? k_r[REC_W-1:0] : jm1[REC_W-1:0]),
    .rdata (ord_q)
  );

  // next values of control registers
  always_comb begin
    n_nxt         = n_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    wi_nxt        = wi_r;
    after_nxt     = after_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    if (ctrl.ld_in && in_fire) begin
      j_nxt    = n_r;
      wi_nxt   = '0;
      last_nxt = in_chan.last_record;
    end
    if (ctrl.ld_rec) begin
      wi_nxt = '0;
    end
    if (ctrl.wi_inc) begin
      wi_nxt = wi_r + WI_W'(1);
    end
    if (ctrl.set_key) begin
      after_nxt = key_after;
    end
    if (ctrl.set_word) begin
      after_nxt = (name_q > cur_word);
    end
    if (ctrl.shift) begin
      j_nxt = jm1;
    end
    if (ctrl.place) begin
      n_nxt = n_r + CNT_W'(1);
    end
    if (ctrl.k_clr) begin
      k_nxt = '0;
    end
    if (emit_go) begin
      k_nxt         = k_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.n_clr) begin
      n_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      wi_r        <= '0;
      after_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r         <= n_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      wi_r        <= wi_nxt;
      after_r     <= after_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture of the new record and of each result
  always_ff @(posedge clk) begin
    if (ctrl.ld_in && in_fire) begin
      ng_r <= in_chan.grade;
      ns_r <= in_chan.specialty;
      for (int w = 0; w < NAME_WORDS; w++) begin
        name_r[w] <= in_words[w];
      end
    end
    if (ctrl.ld_rec) begin
      rec_r <= ord_q;
    end
    if (emit_go) begin
      out_rec_r  <= RECNUM_W'(ord_q);
      out_last_r <= ((k_r + CNT_W'(1)) == n_r);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.record_number = out_rec_r;
  assign out_chan.last_of_run   = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/iisck_ram.sv
// ----------------------------------------------------------------------------
// iisck_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module iisck_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/iisck_seq.sv
// ----------------------------------------------------------------------------
// iisck_seq: microcode sequencer of the index sorter
// Step counter over the microcode table, with conditional jumps taken on
// datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

module iisck_seq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire iisck_pkg::iisck_stat_t stat,
  output iisck_pkg::iisck_ctrl_t      ctrl
);
  import iisck_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  iisck_ctrl_t     word;
  logic            take;

  // fetch control word
  assign word = ucode(pc_r);
  assign ctrl = word;

  // jump condition select
  always_comb begin
    case (word.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !stat.in_fire;
      C_FULL:      take = stat.full;
      C_W_MORE:    take = !stat.w_last;
      C_J_ZERO:    take = stat.j_zero;
      C_KEY_NE:    take = stat.key_ne;
      C_WORD_NE:   take = stat.word_ne;
      C_W_LAST:    take = stat.w_last;
      C_NOT_AFTER: take = !stat.after;
      C_NOT_LAST:  take = !stat.last;
      C_OUT_BUSY:  take = stat.out_busy;
      C_K_MORE:    take = stat.k_more;
      default:     take = 1'b0;
    endcase
  end

  // next step
  assign pc_nxt = take ? word.target : pc_r + PC_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: test/index_insertion_sort_composite_key_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// index_insertion_sort_composite_key_tb: self-checking bench for the sorter
// Loads sets of records over the input channel and checks every sorted
// record number against a model kept in the bench: a short directed table
// (key extremes, specialty codes, surname ties and byte order) and then
// random sets, one of them filling the store exactly and one overflowing it.
// Input bursts and output stalls are random.
// ----------------------------------------------------------------------------

module index_insertion_sort_composite_key_tb;
  import iisck_pkg::*;

  typedef logic [0:IN_WORDS-1][WORD_W-1:0] name_t;

  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [SPEC_W-1:0]  specialty;
    name_t              surname;
    logic               last_record;
  } rec_item_t;

  typedef struct packed {
    logic [RECNUM_W-1:0] record_number;
    logic                last_of_run;
  } rank_t;

  typedef struct packed {
    rec_item_t           item;
    int                  n_known;   // -1: ranks come from the sort model
    logic [0:3][RECNUM_W-1:0] known;
  } stim_row_t;

  logic clk;
  logic rst_n;

  iisck_in_if  in_if ();
  iisck_out_if out_if ();

  index_insertion_sort_composite_key u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // sort model state
  logic [GRADE_W-1:0]  grade_mem [MAX_RECORDS];
  logic [SPEC_W-1:0]   spec_mem  [MAX_RECORDS];
  name_t               name_mem  [MAX_RECORDS];
  logic [RECNUM_W-1:0] order_mem [MAX_RECORDS];
  int                  stored_cnt;

  rank_t     rank_q[$];
  stim_row_t directed_rows[$];
  name_t     name_pool[$];

  int err_cnt;
  int rec_sent;
  int sets_sent;
  int ranks_checked;
  int dropped_cnt;
  int burst_left;
  bit no_idle;
  logic [GRADE_W-1:0] grade_base;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // true when stored record a belongs after stored record b
  function automatic bit sorts_after(int a, int b);
    if (grade_mem[a] != grade_mem[b]) return grade_mem[a] < grade_mem[b];
    if (spec_mem[a] != spec_mem[b]) return spec_mem[a] > spec_mem[b];
    for (int w = 0; w < NAME_WORDS; w++) begin
      if (name_mem[a][w] != name_mem[b][w]) return name_mem[a][w] > name_mem[b][w];
    end
    return 1'b0;
  endfunction

  // load one record into the model, queue the ranks on a last request
  task automatic sort_model_load(rec_item_t it, bit post);
    int slot;
    int j;
    if (stored_cnt < MAX_RECORDS) begin
      slot = stored_cnt;
      grade_mem[slot] = it.grade;
      spec_mem[slot]  = it.specialty;
      name_mem[slot]  = it.surname;
      j = slot;
      while (j > 0 && sorts_after(order_mem[j-1], slot)) begin
        order_mem[j] = order_mem[j-1];
        j--;
      end
      order_mem[j] = RECNUM_W'(slot);
      stored_cnt++;
    end else begin
      dropped_cnt++;
    end
    if (it.last_record) begin
      if (post) begin
        for (int k = 0; k < stored_cnt; k++)
          rank_q.push_back('{order_mem[k], k == stored_cnt - 1});
      end
      stored_cnt = 0;
      sets_sent++;
      name_pool.delete();
    end
  endtask

  function automatic name_t ascii(string s);
    logic [0:IN_WORDS*8-1][7:0] b;
    b = '0;
    for (int i = 0; i < s.len() && i < IN_WORDS * 8; i++) b[i] = s[i];
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic stim_row_t drow(logic [GRADE_W-1:0] g, logic [SPEC_W-1:0] sp,
                                     name_t nm, logic lr, int nk,
                                     logic [0:3][RECNUM_W-1:0] kn);
    stim_row_t r;
    r.item    = '{g, sp, nm, lr};
    r.n_known = nk;
    r.known   = kn;
    return r;
  endfunction

  // surname: readable text, near copies of names in the set, raw words
  function automatic name_t rand_name();
    logic [0:IN_WORDS*8-1][7:0] b;
    name_t nm;
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      b = '0;
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++)
        b[i] = $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
      nm = b;
    end else if (pick < 7 && name_pool.size() > 0) begin
      nm = name_pool[$urandom_range(0, name_pool.size() - 1)];
      if ($urandom_range(0, 1))
        nm[$urandom_range(0, IN_WORDS - 1)] ^= WORD_W'(1) << $urandom_range(0, WORD_W - 1);
    end else if (pick < 9) begin
      for (int w = 0; w < IN_WORDS; w++) nm[w] = rand_word();
    end else begin
      nm = $urandom_range(0, 1) ? '1 : '0;
    end
    return nm;
  endfunction

  // grades clustered near a per-set base so that ties are common
  function automatic rec_item_t rand_record(logic lr);
    rec_item_t it;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) it.grade = 8'($urandom_range(0, 255));
    else if (pick < 8) it.grade = grade_base + 8'($urandom_range(0, 1));
    else if (pick == 8) it.grade = '0;
    else it.grade = '1;
    it.specialty = ($urandom_range(0, 99) < 85) ? SPEC_W'($urandom_range(0, 4))
                                                 : SPEC_W'($urandom_range(5, 7));
    it.surname = rand_name();
    it.last_record = lr;
    name_pool.push_back(it.surname);
    return it;
  endfunction

  // sender idles between bursts unless in a no-idle stretch
  task automatic take_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!no_idle) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic offer_record(rec_item_t it, int nk, logic [0:3][RECNUM_W-1:0] kn);
    take_gap();
    in_if.valid       <= 1'b1;
    in_if.grade       <= it.grade;
    in_if.specialty   <= it.specialty;
    in_if.surname_w0  <= it.surname[0];
    in_if.surname_w1  <= it.surname[1];
    in_if.surname_w2  <= it.surname[2];
    in_if.surname_w3  <= it.surname[3];
    in_if.surname_w4  <= it.surname[4];
    in_if.surname_w5  <= it.surname[5];
    in_if.surname_w6  <= it.surname[6];
    in_if.last_record <= it.last_record;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sort_model_load(it, nk < 0);
    for (int i = 0; i < nk; i++) rank_q.push_back('{kn[i], i == nk - 1});
    rec_sent++;
  endtask

  task automatic send_set(int size);
    grade_base = 8'($urandom_range(0, 254));
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++)
      offer_record(rand_record(i == size - 1), -1, '0);
  endtask

  task automatic small_sets_until(int target);
    while (rec_sent < target)
      send_set(($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12));
  endtask

  // hold the sender until every queued rank has come back
  task automatic drain_ranks();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (rank_q.size() != 0) @(posedge clk);
  endtask

  // result side: random stall pattern, check each accepted rank
  initial begin : result_side
    rank_t exp_rank;
    int    mode;
    int    mode_left;
    int    cyc;
    out_if.ready = 1'b0;
    mode_left = 0;
    mode = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_if.valid && out_if.ready) begin
        if (rank_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result, expected none, got record %0d last %0b",
                   $time, out_if.record_number, out_if.last_of_run);
        end else begin
          exp_rank = rank_q.pop_front();
          ranks_checked++;
          if (out_if.record_number !== exp_rank.record_number) begin
            err_cnt++;
            $display("%0t: record_number mismatch, expected %0d, got %0d",
                     $time, exp_rank.record_number, out_if.record_number);
          end
          if (out_if.last_of_run !== exp_rank.last_of_run) begin
            err_cnt++;
            $display("%0t: last_of_run mismatch, expected %0b, got %0b",
                     $time, exp_rank.last_of_run, out_if.last_of_run);
          end
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom_range(0, 1));
        2: out_if.ready <= ($urandom_range(0, 3) == 0);
        default: out_if.ready <= ((cyc % 16) < 5);
      endcase
    end
  end

  // stimulus
  initial begin : record_side
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.grade = '0;
    in_if.specialty = '0;
    in_if.surname_w0 = '0;
    in_if.surname_w1 = '0;
    in_if.surname_w2 = '0;
    in_if.surname_w3 = '0;
    in_if.surname_w4 = '0;
    in_if.surname_w5 = '0;
    in_if.surname_w6 = '0;
    in_if.last_record = 1'b0;
    err_cnt = 0;
    rec_sent = 0;
    sets_sent = 0;
    ranks_checked = 0;
    dropped_cnt = 0;
    stored_cnt = 0;
    burst_left = 0;
    no_idle = 1'b0;
    grade_base = '0;

    // single record right after reset
    directed_rows.push_back(drow(8'd200, 3'd2, ascii("SMITH"), 1'b1, 1, '{6'd0, 6'd0, 6'd0, 6'd0}));
    // grade extremes: highest grade first
    directed_rows.push_back(drow(8'd0, 3'd0, '0, 1'b0, 0, '0));
    directed_rows.push_back(drow(8'd255, 3'd4, '1, 1'b1, 2, '{6'd1, 6'd0, 6'd0, 6'd0}));
    // every specialty code, out-of-range codes included, at one grade
    directed_rows.push_back(drow(8'd100, 3'd4, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd0, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd7, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd3, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd1, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd5, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd2, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd6, ascii("B"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd100, 3'd0, ascii("A"), 1'b1, -1, '0));
    // surname ties: prefix, identical names stay in load order, last word only
    directed_rows.push_back(drow(8'd50, 3'd1, ascii("ADAMS"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, ascii("ADAM"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, ascii("ADAMS"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, {ascii("X")} | name_t'(1), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, ascii("X"), 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, '1, 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd50, 3'd1, '0, 1'b1, -1, '0));
    // bytes compare unsigned: 0x80 sorts after 0x7f
    directed_rows.push_back(drow(8'd7, 3'd4, {8'h80, 440'h0}, 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd7, 3'd4, {8'h7f, 440'h0}, 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd7, 3'd4, {8'hff, 440'h0}, 1'b0, -1, '0));
    directed_rows.push_back(drow(8'd7, 3'd4, {8'h00, 8'h01, 432'h0}, 1'b1, -1, '0));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_record(directed_rows[i].item, directed_rows[i].n_known, directed_rows[i].known);
    drain_ranks();

    // random sets; one fills the store exactly, one overflows it
    small_sets_until(150);
    send_set(MAX_RECORDS);
    drain_ranks();
    small_sets_until(220);
    send_set(MAX_RECORDS + 2);
    small_sets_until(380);

    drain_ranks();
    repeat (40) @(posedge clk);

    $display("covered %0d records in %0d sets (%0d dropped on a full store)",
             rec_sent, sets_sent, dropped_cnt);
    $display("checked %0d sorted record numbers, %0d mismatches", ranks_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/iisck_pkg.sv
rtl/iisck_if.sv
rtl/iisck_ram.sv
rtl/iisck_seq.sv
rtl/index_insertion_sort_composite_key.sv
test/index_insertion_sort_composite_key_tb.sv
